// ----- sv/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants of the port step predictor
// Field widths, result kind codes, register indexes and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package psp_pkg;

    localparam int PORT_BITS      = 16;
    localparam int FIELD_BITS     = PORT_BITS + 1;
    localparam int MAG_BITS       = PORT_BITS + 1;
    localparam int CFG_BITS       = 8;
    localparam int SPREAD_BITS    = MAG_BITS + CFG_BITS;
    localparam int SHIFT_BITS     = $clog2(PORT_BITS + 1);
    localparam int CFG_INDEX_BITS = 1;

    // Reset values of the configuration registers
    localparam logic [CFG_BITS-1:0] SMALL_GCD_LIMIT_RESET = 8'd3;
    localparam logic [CFG_BITS-1:0] SPREAD_FACTOR_RESET   = 8'd20;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SMALL_GCD_LIMIT = 1'b0,
        CFG_SPREAD_FACTOR   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_EQUAL     = 2'd1,
        KIND_DIVISIBLE = 2'd2,
        KIND_GCD       = 2'd3
    } step_kind_t;

    typedef struct packed {
        logic load;     // capture a new item
        logic step;     // one binary GCD iteration
        logic gval;     // form the GCD from the odd part and the shift count
        logic spread;   // multiply the GCD by the spread factor
        logic finish;   // decide and load the output register
    } psp_cmd_t;

    typedef struct packed {
        logic gcd_done; // operands equal, or the item needs no GCD
    } psp_stat_t;

endpackage

// ----- sv/psp_if.sv -----
// ----------------------------------------------------------------------------
// psp_in_if / psp_out_if: valid/ready channels of the port step predictor
// Input channel carries the two observed steps, output channel the
// predicted step and its kind.
// ----------------------------------------------------------------------------
interface psp_in_if import psp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] step_first;
    logic signed [FIELD_BITS-1:0] step_second;

    modport source (output valid, output step_first, output step_second, input ready);
    modport sink   (input valid, input step_first, input step_second, output ready);
endinterface

interface psp_out_if import psp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] predicted_step;
    logic [1:0]                   step_kind;

    modport source (output valid, output predicted_step, output step_kind, input ready);
    modport sink   (input valid, input predicted_step, input step_kind, output ready);
endinterface

// ----- sv/psp_ctrl.sv -----
// ----------------------------------------------------------------------------
// psp_ctrl: sequencer of the port step predictor
// Accepts one item, runs the GCD loop to completion, forms the spread
// product and loads the output register, which it then hands off.
// ----------------------------------------------------------------------------
module psp_ctrl import psp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  psp_stat_t stat,
    output psp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_GCD    = 5'b00010,
        ST_GVAL   = 5'b00100,
        ST_SPREAD = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Sequence the item through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (stat.gcd_done)
                    state_next = ST_GVAL;
                else
                    cmd.step = 1'b1;
            end
            ST_GVAL:
            begin
                cmd.gval   = 1'b1;
                state_next = ST_SPREAD;
            end
            ST_SPREAD:
            begin
                cmd.spread = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Raise valid on a new result, drop it once the transfer completes
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A transfer into the block always starts the GCD loop
    a_load_to_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_GCD))
        else $error("accepted item did not enter the GCD loop");

    // A new result only appears out of the finish step
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output valid raised outside the finish step");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

endmodule

// ----- sv/psp_dp.sv -----
// ----------------------------------------------------------------------------
// psp_dp: datapath of the port step predictor
// Holds the configuration registers, the operand registers, a binary GCD
// unit with one iteration per step, the spread multiplier and the output
// payload register.
// ----------------------------------------------------------------------------
module psp_dp import psp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic signed [FIELD_BITS-1:0] step_first,
    input  logic signed [FIELD_BITS-1:0] step_second,
    output logic signed [FIELD_BITS-1:0] predicted_step,
    output logic [1:0]                   step_kind,
    input  psp_cmd_t                     cmd,
    output psp_stat_t                    stat
);

    logic [CFG_BITS-1:0]          limit_reg, limit_next;
    logic [CFG_BITS-1:0]          factor_reg, factor_next;
    logic signed [FIELD_BITS-1:0] a_reg, b_reg;
    logic [MAG_BITS-1:0]          ma_reg, mb_reg;
    logic [MAG_BITS-1:0]          x_reg, x_next;
    logic [MAG_BITS-1:0]          y_reg, y_next;
    logic [SHIFT_BITS-1:0]        k_reg, k_next;
    logic                         trivial_reg;
    logic [MAG_BITS-1:0]          g_reg;
    logic [SPREAD_BITS-1:0]       spread_reg;
    logic signed [FIELD_BITS-1:0] result_reg, result_next;
    step_kind_t                   kind_reg, kind_next;

    logic [MAG_BITS-1:0]          ma_in, mb_in;
    logic                         both_neg;
    logic [MAG_BITS-1:0]          g_shifted;
    logic signed [FIELD_BITS-1:0] g_signed;

    // Magnitudes of the incoming steps; the most negative step gives 2^PORT_BITS
    assign ma_in = step_first[FIELD_BITS-1]  ? MAG_BITS'(-step_first)  : MAG_BITS'(step_first);
    assign mb_in = step_second[FIELD_BITS-1] ? MAG_BITS'(-step_second) : MAG_BITS'(step_second);

    assign stat.gcd_done = trivial_reg || (x_reg == y_reg);

    // Write the configuration registers
    always_comb
    begin
        limit_next  = limit_reg;
        factor_next = factor_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SMALL_GCD_LIMIT: limit_next  = cfg_data;
                CFG_SPREAD_FACTOR:   factor_next = cfg_data;
                default:             limit_next  = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= SMALL_GCD_LIMIT_RESET;
            factor_reg <= SPREAD_FACTOR_RESET;
        end
        else
        begin
            limit_reg  <= limit_next;
            factor_reg <= factor_next;
        end
    end

    // One binary GCD iteration: halve even operands, subtract odd ones
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_next = k_reg;
        if (cmd.load)
        begin
            x_next = ma_in;
            y_next = mb_in;
            k_next = '0;
        end
        else if (cmd.step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + SHIFT_BITS'(1);
            end
            else if (!x_reg[0])
                x_next = x_reg >> 1;
            else if (!y_reg[0])
                y_next = y_reg >> 1;
            else if (x_reg > y_reg)
                x_next = x_reg - y_reg;
            else
                y_next = y_reg - x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            k_reg <= k_next;
        end
    end

    // Capture the item; equal or zero steps need no GCD
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trivial_reg <= 1'b1;
        else if (cmd.load)
            trivial_reg <= (step_first == step_second) || (ma_in == '0) || (mb_in == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg  <= step_first;
            b_reg  <= step_second;
            ma_reg <= ma_in;
            mb_reg <= mb_in;
        end
    end

    // Restore the common power of two, then scale by the spread factor
    assign g_shifted = x_reg << k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.gval)
            g_reg <= g_shifted;
        if (cmd.spread)
            spread_reg <= SPREAD_BITS'(g_reg) * SPREAD_BITS'(factor_reg);
    end

    // Classify the pair; a GCD equal to the smaller magnitude means it divides the other
    assign both_neg = a_reg[FIELD_BITS-1] && b_reg[FIELD_BITS-1];
    assign g_signed = FIELD_BITS'(g_reg);

    always_comb
    begin
        result_next = '0;
        kind_next   = KIND_NONE;
        if (a_reg == b_reg)
        begin
            if (a_reg != '0)
            begin
                result_next = a_reg;
                kind_next   = KIND_EQUAL;
            end
        end
        else if (!trivial_reg)
        begin
            if ((ma_reg > mb_reg) && (g_reg == mb_reg))
            begin
                result_next = both_neg ? -b_reg : b_reg;
                kind_next   = KIND_DIVISIBLE;
            end
            else if ((mb_reg > ma_reg) && (g_reg == ma_reg))
            begin
                result_next = both_neg ? -a_reg : a_reg;
                kind_next   = KIND_DIVISIBLE;
            end
            else if ((g_reg > MAG_BITS'(limit_reg))
                     && !((spread_reg < SPREAD_BITS'(ma_reg))
                          && (spread_reg < SPREAD_BITS'(mb_reg))))
            begin
                result_next = both_neg ? -g_signed : g_signed;
                kind_next   = KIND_GCD;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= result_next;
            kind_reg   <= kind_next;
        end
    end

    assign predicted_step = result_reg;
    assign step_kind      = kind_reg;

    // GCD iterations only run on two nonzero operands
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((x_reg != '0) && (y_reg != '0)))
        else $error("GCD iteration on a zero operand");

    // The GCD is taken only once the loop has converged
    a_gval_converged: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gval |-> (trivial_reg || (x_reg == y_reg)))
        else $error("GCD formed before convergence");

    // The common power of two never exceeds the port width
    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= SHIFT_BITS'(PORT_BITS))
        else $error("GCD shift count out of range");

endmodule

// ----- sv/port_step_predictor.sv -----
// ----------------------------------------------------------------------------
// port_step_predictor: NAT port allocation step predictor
// Flow: load, the binary GCD loop (one halving or subtraction per cycle; none for
//   equal or zero steps), GCD, spread and finish, which waits for a free output.
// Throughput: one item at a time; the next item is accepted the cycle after a
//   result is loaded into the output register, even while it waits.
// Reset: asynchronous, active low; the controller returns to idle, the output
//   register empties and the configuration registers take their reset values.
// ----------------------------------------------------------------------------
module port_step_predictor import psp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,
    psp_in_if.sink                    in_ch,
    psp_out_if.source                 out_ch
);

    psp_cmd_t  cmd;
    psp_stat_t stat;

    // Sequence one item at a time
    psp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Compute the GCD and the prediction
    psp_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .step_first     (in_ch.step_first),
        .step_second    (in_ch.step_second),
        .predicted_step (out_ch.predicted_step),
        .step_kind      (out_ch.step_kind),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
